/* sv/apt_pkg.sv */
package apt_pkg;

    typedef enum logic [1:0] {
        CMD_TRANSLATE = 2'd0,
        CMD_SCALE     = 2'd1,
        CMD_ROTATE    = 2'd2,
        CMD_REFLECT   = 2'd3
    } apt_cmd_t;

    // cordic datapath is q2.30 with headroom
    localparam int CW = 33;
    localparam int ZW = 33;
    localparam int RADW = 26;
    localparam logic signed [RADW-1:0] RAD_Q30 = 26'sd18740330;
    localparam logic signed [CW-1:0] GAIN_Q30 = 33'sd652032874;

    typedef struct packed {
        apt_cmd_t           cmd;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] param_a;
        logic signed [31:0] param_b;
    } apt_in_t;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] row0_col0;
        logic signed [31:0] row0_col1;
        logic signed [31:0] row0_col2;
        logic signed [31:0] row1_col0;
        logic signed [31:0] row1_col1;
        logic signed [31:0] row1_col2;
    } apt_out_t;

    typedef struct packed {
        apt_in_t req;
        logic    neg;
    } apt_side_t;

    typedef struct packed {
        apt_side_t            side;
        logic signed [CW-1:0] xc;
        logic signed [CW-1:0] yc;
    } apt_cord_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'd843314857;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043837;
            5'd3:  v = 32'd133525159;
            5'd4:  v = 32'd67021687;
            5'd5:  v = 32'd33543516;
            5'd6:  v = 32'd16775851;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194283;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048576;
            5'd11: v = 32'd524288;
            5'd12: v = 32'd262144;
            5'd13: v = 32'd131072;
            5'd14: v = 32'd65536;
            5'd15: v = 32'd32768;
            5'd16: v = 32'd16384;
            5'd17: v = 32'd8192;
            5'd18: v = 32'd4096;
            5'd19: v = 32'd2048;
            5'd20: v = 32'd1024;
            5'd21: v = 32'd512;
            5'd22: v = 32'd256;
            5'd23: v = 32'd128;
            5'd24: v = 32'd64;
            5'd25: v = 32'd32;
            5'd26: v = 32'd16;
            5'd27: v = 32'd8;
            5'd28: v = 32'd4;
            5'd29: v = 32'd2;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* sv/apt_front.sv */
module apt_front
    import apt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  apt_in_t              in_word,
    output logic                 out_valid,
    output apt_side_t            out_side,
    output logic signed [ZW-1:0] out_z
);

    localparam int IPW = 33 - FRAC_BITS;
    localparam int UW = IPW + 1;
    localparam int S = UW + 9;
    localparam int MW = S - 7;
    localparam int QW = UW - 8;
    localparam int RW = FRAC_BITS + 10;
    localparam int PW = RW + RADW;
    localparam longint OFF_L = 360 * (((longint'(1) << (IPW - 1)) + 359) / 360);
    localparam longint M_L = ((longint'(1) << S) + 359) / 360;
    localparam longint HALF_L = longint'(180) << FRAC_BITS;
    localparam logic signed [RW-1:0] HALF = RW'(HALF_L);
    localparam logic signed [RW-1:0] QUARTER = RW'(HALF_L / 2);
    localparam logic signed [RW-1:0] FULL = RW'(HALF_L * 2);
    localparam logic signed [PW-1:0] RND = PW'(longint'(1) << (FRAC_BITS - 1));

    logic [4:0]            v_reg;
    apt_side_t             s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    logic [UW-1:0]         u_reg, u2_reg;
    logic [FRAC_BITS-1:0]  f1_reg, f2_reg;
    logic [QW-1:0]         q_reg;
    logic signed [RW-1:0]  r_reg;
    logic signed [PW-1:0]  p_reg;
    logic signed [ZW-1:0]  z_reg;

    logic signed [32:0]    deg;
    logic signed [UW-1:0]  ipx;
    logic [UW-1:0]         u_next;
    logic [UW+MW-1:0]      prod;
    logic [UW-1:0]         q360;
    logic [8:0]            rm;
    logic signed [RW-1:0]  r0, r1, r_next;
    logic                  neg_next;
    logic signed [PW-1:0]  pr;

    always_comb
    begin
        deg = (in_word.cmd == CMD_REFLECT) ? {in_word.param_a, 1'b0}
                                           : {in_word.param_a[31], in_word.param_a};
        // floor of the integer degrees, biased positive by a multiple of 360
        ipx = UW'(signed'(deg[32:FRAC_BITS]));
        u_next = UW'($unsigned(ipx) + UW'(OFF_L));
        prod = UW'(u_reg) * MW'(M_L);
        q360 = UW'(q_reg) * UW'(360);
        rm = 9'(u2_reg - q360);
        r0 = signed'({1'b0, rm, f2_reg});
        r1 = (r0 >= HALF) ? r0 - FULL : r0;
        neg_next = 1'b0;
        r_next = r1;
        if (r1 > QUARTER)
        begin
            r_next = r1 - HALF;
            neg_next = 1'b1;
        end
        else if (r1 < -QUARTER)
        begin
            r_next = r1 + HALF;
            neg_next = 1'b1;
        end
        pr = PW'(r_reg) * PW'(RAD_Q30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= '{req: in_word, neg: 1'b0};
        u_reg  <= u_next;
        f1_reg <= deg[FRAC_BITS-1:0];
        s2_reg <= s1_reg;
        q_reg  <= prod[S +: QW];
        u2_reg <= u_reg;
        f2_reg <= f1_reg;
        s3_reg <= '{req: s2_reg.req, neg: neg_next};
        r_reg  <= r_next;
        s4_reg <= s3_reg;
        p_reg  <= pr;
        s5_reg <= s4_reg;
        z_reg  <= ZW'((p_reg + RND) >>> FRAC_BITS);
    end

    assign out_valid = v_reg[4];
    assign out_side  = s5_reg;
    assign out_z     = z_reg;

endmodule

/* sv/apt_cordic.sv */
module apt_cordic
    import apt_pkg::*;
#(
    parameter int STAGES = 18
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  apt_side_t            in_side,
    input  logic signed [ZW-1:0] in_z,
    output logic                 out_valid,
    output apt_cord_t            out_word
);

    logic [STAGES:0]      v_reg;
    logic signed [CW-1:0] x_reg [0:STAGES];
    logic signed [CW-1:0] y_reg [0:STAGES];
    logic signed [ZW-1:0] z_reg [0:STAGES];
    apt_side_t            s_reg [0:STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0] <= GAIN_Q30;
        y_reg[0] <= '0;
        z_reg[0] <= in_z;
        s_reg[0] <= in_side;
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q30(5'(i)));
        always_ff @(posedge clk)
        begin
            if (z_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - ATAN;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + ATAN;
            end
            s_reg[i+1] <= s_reg[i];
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_word  = '{side: s_reg[STAGES], xc: x_reg[STAGES], yc: y_reg[STAGES]};

endmodule

/* sv/apt_queue.sv */
module apt_queue
    import apt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  apt_cord_t push_word,
    output logic      full,
    output logic      out_valid,
    output apt_cord_t out_word
);

    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);

    apt_cord_t       mem [0:DEPTH-1];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;
    logic            valid_reg;
    apt_cord_t       out_reg;
    logic            pop;

    // the back end never stalls, so drain a word every cycle there is one
    assign pop  = (cnt_reg != '0);
    assign full = (cnt_reg == (AW+1)'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg   <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
            valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_word;
        end
        out_reg <= mem[rd_reg];
    end

    assign out_valid = valid_reg;
    assign out_word  = out_reg;

endmodule

/* sv/apt_back.sv */
module apt_back
    import apt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  apt_cord_t in_word,
    output logic      done,
    output apt_out_t  rsp
);

    localparam int SH = 30 - FRAC_BITS;
    localparam int AW = 66;
    localparam logic signed [CW-1:0] RND_C = CW'(longint'(1) << (SH - 1));
    localparam logic signed [CW-1:0] ONE_C = CW'(longint'(1) << FRAC_BITS);
    localparam logic signed [31:0] ONE = 32'(longint'(1) << FRAC_BITS);
    localparam logic signed [AW-1:0] RND = AW'(longint'(1) << (FRAC_BITS - 1));
    localparam logic signed [AW-1:0] SMAX = AW'(64'sh7fffffff);
    localparam logic signed [AW-1:0] SMIN = -AW'(64'sh80000000);

    logic [2:0]           v_reg;
    logic signed [31:0]   m_reg [0:5];
    logic signed [31:0]   m2_reg [0:5];
    logic signed [31:0]   x_reg, y_reg;
    logic signed [63:0]   p_reg [0:3];

    logic signed [CW-1:0] cr, sr, cc, ss;
    logic signed [31:0]   c, s;
    logic signed [31:0]   m_next [0:5];
    logic signed [AW-1:0] acc0, acc1, t0, t1;
    apt_out_t             rsp_reg;

    always_comb
    begin
        cr = (in_word.xc + RND_C) >>> SH;
        sr = (in_word.yc + RND_C) >>> SH;
        cc = (cr > ONE_C) ? ONE_C : ((cr < -ONE_C) ? -ONE_C : cr);
        ss = (sr > ONE_C) ? ONE_C : ((sr < -ONE_C) ? -ONE_C : sr);
        if (in_word.side.neg)
        begin
            cc = -cc;
            ss = -ss;
        end
        c = 32'(cc);
        s = 32'(ss);
        unique case (in_word.side.req.cmd)
            CMD_TRANSLATE:
            begin
                m_next[0] = ONE; m_next[1] = '0; m_next[2] = in_word.side.req.param_a;
                m_next[3] = '0;  m_next[4] = ONE; m_next[5] = in_word.side.req.param_b;
            end
            CMD_SCALE:
            begin
                m_next[0] = in_word.side.req.param_a; m_next[1] = '0; m_next[2] = '0;
                m_next[3] = '0; m_next[4] = in_word.side.req.param_b; m_next[5] = '0;
            end
            CMD_ROTATE:
            begin
                m_next[0] = c; m_next[1] = -s; m_next[2] = '0;
                m_next[3] = s; m_next[4] = c;  m_next[5] = '0;
            end
            default:
            begin
                m_next[0] = c; m_next[1] = s;  m_next[2] = '0;
                m_next[3] = s; m_next[4] = -c; m_next[5] = '0;
            end
        endcase
    end

    always_comb
    begin
        acc0 = AW'(p_reg[0]) + AW'(p_reg[1]);
        acc1 = AW'(p_reg[2]) + AW'(p_reg[3]);
        t0 = ((acc0 + RND) >>> FRAC_BITS) + AW'(m2_reg[2]);
        t1 = ((acc1 + RND) >>> FRAC_BITS) + AW'(m2_reg[5]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg  <= m_next;
        x_reg  <= in_word.side.req.x_in;
        y_reg  <= in_word.side.req.y_in;
        m2_reg <= m_reg;
        p_reg[0] <= 64'(m_reg[0]) * 64'(x_reg);
        p_reg[1] <= 64'(m_reg[1]) * 64'(y_reg);
        p_reg[2] <= 64'(m_reg[3]) * 64'(x_reg);
        p_reg[3] <= 64'(m_reg[4]) * 64'(y_reg);
        rsp_reg.x_out <= (t0 > SMAX) ? 32'sh7fffffff
                       : ((t0 < SMIN) ? 32'sh80000000 : 32'(t0));
        rsp_reg.y_out <= (t1 > SMAX) ? 32'sh7fffffff
                       : ((t1 < SMIN) ? 32'sh80000000 : 32'(t1));
        rsp_reg.row0_col0 <= m2_reg[0];
        rsp_reg.row0_col1 <= m2_reg[1];
        rsp_reg.row0_col2 <= m2_reg[2];
        rsp_reg.row1_col0 <= m2_reg[3];
        rsp_reg.row1_col1 <= m2_reg[4];
        rsp_reg.row1_col2 <= m2_reg[5];
    end

    assign done = v_reg[2];
    assign rsp  = rsp_reg;

endmodule

/* sv/affine_point_transform_2d.sv */
// 2d affine point transform: translate, scale, rotate or reflect one point
// a command word is taken on req at a rising edge with start high and busy low
// req carries the operation, the point and two q-format parameters
// one result word per command comes back on rsp, marked by done for one cycle
// rsp holds the transformed point (saturated) and the top two matrix rows
// latency is the same for every operation, so order is kept; it is set
// by the cordic pipeline, one stage per iteration, plus angle reduction,
// a short queue and the multiply and round stages
// a new command can be taken every cycle; busy only rises if the queue
// between the sine/cosine front end and the matrix back end were to fill
// the receiver cannot hold results off: each word is shown exactly once
// reset clears all valid flags; words in flight are dropped
module affine_point_transform_2d
    import apt_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int CORDIC_STAGES = 18
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  apt_in_t  req,
    output logic     done,
    output apt_out_t rsp
);

    localparam logic signed [31:0] ONE = 32'(longint'(1) << FRAC_BITS);

    logic                 f_valid;
    apt_side_t            f_side;
    logic signed [ZW-1:0] f_z;
    logic                 c_valid;
    apt_cord_t            c_word;
    logic                 q_valid;
    apt_cord_t            q_word;
    logic                 q_full;

    apt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_word   (req),
        .out_valid (f_valid),
        .out_side  (f_side),
        .out_z     (f_z)
    );

    apt_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .in_z      (f_z),
        .out_valid (c_valid),
        .out_word  (c_word)
    );

    apt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (c_valid),
        .push_word (c_word),
        .full      (q_full),
        .out_valid (q_valid),
        .out_word  (q_word)
    );

    apt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_word  (q_word),
        .done     (done),
        .rsp      (rsp)
    );

    assign busy = q_full;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("queue filled");

    a_offset_only_translate: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.row0_col2 == 0 && rsp.row1_col2 == 0)
              || (rsp.row0_col0 == ONE && rsp.row1_col1 == ONE))
        else $error("offset column on a linear operation");

    a_trig_pairs: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.row0_col1 == -rsp.row1_col0) || (rsp.row0_col1 == rsp.row1_col0))
        else $error("off-diagonal entries disagree");

endmodule
